// File: sv/mwsd_pkg.sv
// Shared types and constants of the mask window steering decider.
`timescale 1ns / 1ps
`default_nettype none

package mwsd_pkg;

    // Field widths
    localparam int CLASS_W   = 8;
    localparam int COORD_W   = 12;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;
    localparam int NUM_WIN   = 3;

    // Decoupling queue between classifier and counter
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Segmentation classes
    localparam logic [CLASS_W-1:0] CLS_PATH_A = 8'd0;
    localparam logic [CLASS_W-1:0] CLS_PATH_B = 8'd2;
    localparam logic [CLASS_W-1:0] CLS_PATH_C = 8'd3;
    localparam logic [CLASS_W-1:0] CLS_PARK_A = 8'd4;
    localparam logic [CLASS_W-1:0] CLS_PARK_B = 8'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEFT     = 4'd0,
        REG_WINDOW_TOP      = 4'd1,
        REG_WINDOW_WIDTH    = 4'd2,
        REG_WINDOW_HEIGHT   = 4'd3,
        REG_SIDE_PATH_LIMIT = 4'd4,
        REG_MID_PATH_LIMIT  = 4'd5,
        REG_SIDE_PARK_LIMIT = 4'd6,
        REG_MID_PARK_LIMIT  = 4'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        CMD_FORWARD = 3'd0,
        CMD_BACK    = 3'd1,
        CMD_LEFT    = 3'd2,
        CMD_RIGHT   = 3'd3,
        CMD_STOP    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        GR_NONE = 2'd0,
        GR_PATH = 2'd1,
        GR_PARK = 2'd2
    } t_grade;

    typedef struct packed {
        logic [COORD_W-1:0] window_left;
        logic [COORD_W-1:0] window_top;
        logic [COORD_W-1:0] window_width;
        logic [COORD_W-1:0] window_height;
        logic [COUNT_W-1:0] side_path_limit;
        logic [COUNT_W-1:0] mid_path_limit;
        logic [COUNT_W-1:0] side_park_limit;
        logic [COUNT_W-1:0] mid_park_limit;
    } t_cfg;

    // One classified pixel as queued for the counter
    typedef struct packed {
        logic               path;
        logic               park;
        logic [NUM_WIN-1:0] hit;
        logic               last;
    } t_cls_item;

    typedef struct packed {
        t_cmd               cmd;
        logic [COUNT_W-1:0] confirm;
        logic               arrived;
    } t_result;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: sv/mwsd_if.sv
// Request channel interfaces: pixel input, result output, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface mwsd_pix_if import mwsd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] pixel_class;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    logic               frame_end;

    modport source (output valid, pixel_class, row_index, col_index, frame_end,
                    input ready);
    modport sink   (input valid, pixel_class, row_index, col_index, frame_end,
                    output ready);
endinterface

interface mwsd_res_if import mwsd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         steer_cmd;
    logic [COUNT_W-1:0] confirm_count;
    logic               arrived;

    modport source (output valid, steer_cmd, confirm_count, arrived, input ready);
    modport sink   (input valid, steer_cmd, confirm_count, arrived, output ready);
endinterface

interface mwsd_cfg_if import mwsd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// File: sv/mwsd_front.sv
// Front end: classifies each pixel request and finds the windows it falls in.
`timescale 1ns / 1ps
`default_nettype none

module mwsd_front import mwsd_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    mwsd_pix_if.sink  i_pix,
    input  t_cfg      i_cfg,
    input  logic      i_q_ready,
    output logic      o_q_valid,
    output t_cls_item o_q_item
);

    localparam int CoordKeep = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] CoordMask = COORD_W'((64'd1 << CoordKeep) - 64'd1);

    logic [COORD_W-1:0] row_m;
    logic [COORD_W-1:0] col_m;
    logic [COORD_W-1:0] rel;
    logic [COORD_W-1:0] half;
    logic [COORD_W-1:0] start [NUM_WIN];
    logic               row_in;
    logic               col_ok;
    logic               is_path;
    logic               is_park;
    logic [NUM_WIN-1:0] hit;

    assign i_pix.ready = i_q_ready;
    assign o_q_valid   = i_pix.valid;

    // Class decode
    always_comb begin
        is_path = 1'b0;
        is_park = 1'b0;
        case (i_pix.pixel_class) inside
            CLS_PATH_A, CLS_PATH_B, CLS_PATH_C: is_path = 1'b1;
            CLS_PARK_A, CLS_PARK_B:             is_park = 1'b1;
            default: ;
        endcase
    end

    // Band and window compares, limits taken without wrap
    assign row_m  = i_pix.row_index & CoordMask;
    assign col_m  = i_pix.col_index & CoordMask;
    assign row_in = (row_m >= i_cfg.window_top) &&
                    ({1'b0, row_m} < ({1'b0, i_cfg.window_top} + {1'b0, i_cfg.window_height}));
    assign col_ok = (col_m >= i_cfg.window_left);
    assign rel    = col_m - i_cfg.window_left;
    assign half   = {1'b0, i_cfg.window_width[COORD_W-1:1]};

    assign start[0] = '0;
    assign start[1] = half;
    assign start[2] = {half[COORD_W-2:0], 1'b0};

    always_comb begin
        for (int i = 0; i < NUM_WIN; i++) begin
            hit[i] = (rel >= start[i]) &&
                     ({1'b0, rel} < ({1'b0, start[i]} + {1'b0, i_cfg.window_width}));
        end
    end

    always_comb begin
        o_q_item.path = is_path;
        o_q_item.park = is_park;
        o_q_item.hit  = (row_in && col_ok) ? hit : '0;
        o_q_item.last = i_pix.frame_end;
    end

endmodule

`default_nettype wire

// File: sv/mwsd_fifo.sv
// Short queue of classified pixels between the front end and the counter.
`timescale 1ns / 1ps
`default_nettype none

module mwsd_fifo import mwsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr_valid,
    output logic      o_wr_ready,
    input  t_cls_item i_wr_item,
    output logic      o_rd_valid,
    input  logic      i_rd_ready,
    output t_cls_item o_rd_item
);

    t_cls_item          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_AW:0]   r_count;
    logic               push;
    logic               pop;

    assign o_wr_ready = (r_count != (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + 1'b1;
            if (pop)  r_rptr <= r_rptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_wr_item;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue fill level past depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_count[FIFO_AW-1:0])
        else $error("queue pointers disagree with fill level");

    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_valid && !i_rd_ready |=> o_rd_valid && $stable(o_rd_item))
        else $error("queue head changed while stalled");
`endif

endmodule

`default_nettype wire

// File: sv/mwsd_back.sv
// Back end: window counters, frame snapshot, grading, steering and confirmation.
`timescale 1ns / 1ps
`default_nettype none

module mwsd_back import mwsd_pkg::*; #(
    parameter int ARRIVE_LIMIT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_cls_item   i_q_item,
    mwsd_res_if.source  o_res
);

    localparam logic [COUNT_W-1:0] ArriveLim = COUNT_W'(ARRIVE_LIMIT);

    logic [COUNT_W-1:0] r_path [NUM_WIN];
    logic [COUNT_W-1:0] r_park [NUM_WIN];
    logic [COUNT_W-1:0] n_path [NUM_WIN];
    logic [COUNT_W-1:0] n_park [NUM_WIN];
    logic [COUNT_W-1:0] r_snap_path [NUM_WIN];
    logic [COUNT_W-1:0] r_snap_park [NUM_WIN];
    logic               r_snap_valid;
    logic [COUNT_W-1:0] r_confirm;
    logic [COUNT_W-1:0] n_confirm;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;
    t_grade             grade [NUM_WIN];
    logic               snap_take;
    logic               snap_free;
    logic               pop;

    assign snap_take = r_snap_valid && (!r_out_valid || o_res.ready);
    assign snap_free = !r_snap_valid || snap_take;
    assign o_q_ready = !i_q_item.last || snap_free;
    assign pop       = i_q_valid && o_q_ready;

    // Count update for the popped pixel
    always_comb begin
        for (int i = 0; i < NUM_WIN; i++) begin
            n_path[i] = (i_q_item.path && i_q_item.hit[i]) ? sat_inc(r_path[i]) : r_path[i];
            n_park[i] = (i_q_item.park && i_q_item.hit[i]) ? sat_inc(r_park[i]) : r_park[i];
        end
    end

    // Window grades from the frame snapshot
    always_comb begin
        for (int i = 0; i < NUM_WIN; i++) begin
            logic [COUNT_W-1:0] plim;
            logic [COUNT_W-1:0] klim;
            plim = (i == 1) ? i_cfg.mid_path_limit : i_cfg.side_path_limit;
            klim = (i == 1) ? i_cfg.mid_park_limit : i_cfg.side_park_limit;
            if (r_snap_park[i] > klim)
                grade[i] = GR_PARK;
            else if (({1'b0, r_snap_path[i]} + {1'b0, r_snap_park[i]}) > {1'b0, plim})
                grade[i] = GR_PATH;
            else
                grade[i] = GR_NONE;
        end
    end

    // Steering choice and confirmation update
    always_comb begin
        n_out.arrived = 1'b0;
        n_out.cmd     = CMD_FORWARD;
        n_confirm     = r_confirm;
        if (r_confirm > ArriveLim) begin
            n_out.cmd     = CMD_STOP;
            n_out.arrived = 1'b1;
        end else if (grade[0] == GR_PARK && grade[1] == GR_PARK && grade[2] == GR_PARK) begin
            n_confirm = sat_inc(r_confirm);
        end else begin
            n_confirm = (r_confirm != '0) ? r_confirm - 1'b1 : r_confirm;
            if (grade[1] == GR_PARK) begin
                if (r_snap_park[0] > r_snap_park[1])      n_out.cmd = CMD_LEFT;
                else if (r_snap_park[2] > r_snap_park[1]) n_out.cmd = CMD_RIGHT;
                else                                      n_out.cmd = CMD_FORWARD;
            end else if (grade[0] == GR_PARK) begin
                n_out.cmd = CMD_LEFT;
            end else if (grade[2] == GR_PARK) begin
                n_out.cmd = CMD_RIGHT;
            end else if (grade[1] == GR_PATH) begin
                n_out.cmd = CMD_FORWARD;
            end else if (grade[0] == GR_PATH) begin
                n_out.cmd = CMD_LEFT;
            end else if (grade[2] == GR_PATH) begin
                n_out.cmd = CMD_RIGHT;
            end else begin
                n_out.cmd = CMD_BACK;
                n_confirm = '0;
            end
        end
        n_out.confirm = n_confirm;
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WIN; i++) begin
                r_path[i] <= '0;
                r_park[i] <= '0;
            end
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_confirm    <= '0;
        end else begin
            if (pop) begin
                for (int i = 0; i < NUM_WIN; i++) begin
                    r_path[i] <= i_q_item.last ? '0 : n_path[i];
                    r_park[i] <= i_q_item.last ? '0 : n_park[i];
                end
            end
            if (pop && i_q_item.last) r_snap_valid <= 1'b1;
            else if (snap_take)       r_snap_valid <= 1'b0;
            if (snap_take) begin
                r_out_valid <= 1'b1;
                r_confirm   <= n_confirm;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (pop && i_q_item.last) begin
            for (int i = 0; i < NUM_WIN; i++) begin
                r_snap_path[i] <= n_path[i];
                r_snap_park[i] <= n_park[i];
            end
        end
        if (snap_take) r_out <= n_out;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.steer_cmd     = r_out.cmd;
    assign o_res.confirm_count = r_out.confirm;
    assign o_res.arrived       = r_out.arrived;

`ifndef SYNTHESIS
    a_arrived_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.arrived |-> r_out.cmd == CMD_STOP)
        else $error("arrival without stop command");

    a_back_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.cmd == CMD_BACK |-> r_out.confirm == '0)
        else $error("back command left confirmation count set");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid && !snap_take |=> r_snap_valid)
        else $error("frame snapshot lost before grading");

    a_confirm_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !snap_take |=> $stable(r_confirm))
        else $error("confirmation count moved outside a frame decision");
`endif

endmodule

`default_nettype wire

// File: sv/mask_window_steering_decider.sv
// Top level of the mask window steering decider: register file and block wiring.
//
//  Channel  Dir  Payload                                         Accepted when
//  i_pix    in   pixel_class, row_index, col_index, frame_end    valid && ready
//  o_res    out  steer_cmd, confirm_count, arrived               valid && ready
//  i_cfg    in   reg_index, wr_data                              valid && ready
//
// One pixel request per cycle while the queue has room; the front end classifies
// combinationally into a 4-entry queue, the counter pops one entry per cycle
// unless a frame-end pixel waits for the snapshot. A frame-end pixel passes the
// queue, the count snapshot, then the graded output register.
// Reset (i_rst_n low, synchronous) clears counters, queue and confirmation and
// loads register defaults. A stalled result holds one snapshot; after that the
// counter stops at the next frame-end pixel and the queue fills back to i_pix.
`timescale 1ns / 1ps
`default_nettype none

module mask_window_steering_decider import mwsd_pkg::*; #(
    parameter int ARRIVE_LIMIT = 10,
    parameter int COORD_BITS   = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwsd_pix_if.sink   i_pix,
    mwsd_res_if.source o_res,
    mwsd_cfg_if.sink   i_cfg
);

    t_cfg      r_cfg;
    logic      f_valid;
    logic      f_ready;
    t_cls_item f_item;
    logic      q_valid;
    logic      q_ready;
    t_cls_item q_item;

    assign i_cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_left     <= '0;
            r_cfg.window_top      <= '0;
            r_cfg.window_width    <= COORD_W'(64);
            r_cfg.window_height   <= COORD_W'(32);
            r_cfg.side_path_limit <= '0;
            r_cfg.mid_path_limit  <= '0;
            r_cfg.side_park_limit <= '0;
            r_cfg.mid_park_limit  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_WINDOW_LEFT:     r_cfg.window_left     <= i_cfg.wr_data[COORD_W-1:0];
                REG_WINDOW_TOP:      r_cfg.window_top      <= i_cfg.wr_data[COORD_W-1:0];
                REG_WINDOW_WIDTH:    r_cfg.window_width    <= i_cfg.wr_data[COORD_W-1:0];
                REG_WINDOW_HEIGHT:   r_cfg.window_height   <= i_cfg.wr_data[COORD_W-1:0];
                REG_SIDE_PATH_LIMIT: r_cfg.side_path_limit <= i_cfg.wr_data[COUNT_W-1:0];
                REG_MID_PATH_LIMIT:  r_cfg.mid_path_limit  <= i_cfg.wr_data[COUNT_W-1:0];
                REG_SIDE_PARK_LIMIT: r_cfg.side_park_limit <= i_cfg.wr_data[COUNT_W-1:0];
                REG_MID_PARK_LIMIT:  r_cfg.mid_park_limit  <= i_cfg.wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    mwsd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_pix     (i_pix),
        .i_cfg     (r_cfg),
        .i_q_ready (f_ready),
        .o_q_valid (f_valid),
        .o_q_item  (f_item)
    );

    mwsd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_item  (f_item),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_item  (q_item)
    );

    mwsd_back #(
        .ARRIVE_LIMIT (ARRIVE_LIMIT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_item  (q_item),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire
